// ----- hdl/rvtsc_pkg.sv -----
// Package for the velocity texture and spin censor.
// Holds register indexes, reset values, interest levels and small helpers.
// No dependencies.
package rvtsc_pkg;

  localparam int MAX_GATES_DEF    = 4096;
  localparam int WINDOW_GATES_DEF = 5;

  localparam logic [1:0] REG_NYQUIST   = 2'd0;
  localparam logic [1:0] REG_TEX_UPPER = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  localparam logic [14:0] NYQUIST_RST   = 15'd6400;
  localparam logic [15:0] TEX_UPPER_RST = 16'd49152;
  localparam logic [15:0] THRESHOLD_RST = 16'd19661;

  localparam logic [15:0] LOW_INTEREST  = 16'd655;
  localparam logic [15:0] HIGH_INTEREST = 16'd64881;
  localparam logic [15:0] SAT_INTEREST  = 16'd65535;

  // S-curve numerator: a 32-bit square scaled by 2^17
  localparam int CURVE_NUM_W = 49;
  localparam int DIVISOR_W   = 32;

  // a folded difference can reach nearly 2^16 when Nyquist is small
  function automatic logic [16:0] mag17(input logic signed [16:0] x);
    logic [16:0] n;
    begin
      n = x[16] ? 17'(-x) : 17'(x);
      mag17 = n;
    end
  endfunction

endpackage

// ----- hdl/rvtsc_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// The dividend is left-aligned; steps sets how many bits are taken.
// Depends on rvtsc_pkg.
module rvtsc_div #(
  parameter int DW  = rvtsc_pkg::CURVE_NUM_W,
  parameter int VW  = rvtsc_pkg::DIVISOR_W,
  parameter int STW = $clog2(DW + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  input  logic [STW-1:0] steps,
  output logic          done,
  output logic [DW-1:0] quotient
);

  logic           busy;
  logic [STW-1:0] cnt;
  logic [DW-1:0]  dreg;
  logic [VW-1:0]  dvs;
  logic [VW:0]    rem;
  logic [VW:0]    rem_sh;
  logic [VW:0]    rem_next;
  logic           ge;

  always_comb begin
    rem_sh   = {rem[VW-1:0], dreg[DW-1]};
    ge       = rem_sh >= {1'b0, dvs};
    rem_next = ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - STW'(1);
        if (cnt == STW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dreg     <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dreg     <= {dreg[DW-2:0], 1'b0};
      rem      <= rem_next;
      quotient <= {quotient[DW-2:0], ge};
    end
  end

endmodule

// ----- hdl/rvtsc_sqrt.sv -----
// Bit-serial integer square root, two radicand bits per cycle.
// Gives floor(sqrt(radicand)) in root.
// No package dependencies.
module rvtsc_sqrt #(
  parameter int SQW = 52,
  parameter int RTW = SQW / 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [SQW-1:0] radicand,
  output logic           done,
  output logic [RTW-1:0] root
);

  localparam int CW = $clog2(RTW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [SQW-1:0] rad;
  logic [RTW:0]   rem;
  logic [RTW+2:0] rem_sh;
  logic [RTW+2:0] trial;
  logic [RTW+2:0] rem_next;
  logic           ge;

  always_comb begin
    rem_sh   = {rem, rad[SQW-1:SQW-2]};
    trial    = {1'b0, root, 2'b01};
    ge       = rem_sh >= trial;
    rem_next = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(RTW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[SQW-3:0], 2'b00};
      rem  <= rem_next[RTW:0];
      root <= {root[RTW-2:0], ge};
    end
  end

endmodule

// ----- hdl/radar_velocity_texture_spin_censor_unit.sv -----
// Top level of the velocity texture and spin censor.
// Depends on rvtsc_pkg, rvtsc_div and rvtsc_sqrt.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one range gate per transaction:
//   velocity, missing flag and end_of_beam. Output channel (out_valid/
//   out_ready) returns one result per transaction, WINDOW_GATES/2 gates late;
//   the end_of_beam gate also releases the remaining gates of the beam, the
//   last one marked beam_done.
//   Gates are worked one at a time. A gate with a full window runs the
//   squares, then the shared serial divider for the mean square (one bit a
//   cycle, 32+clog2(WINDOW_GATES) bits), the serial square root, the divide
//   by Nyquist and up to two S-curve divides (a trivial end of the curve
//   skips its divide). Gates at the beam start skip the arithmetic. The
//   serial divider sets the rate.
//   A finished result waits in the output register while the next gate is
//   already taken; a stalled receiver holds the block only when a further
//   result is due.
//   Reset (rst, synchronous) clears the windows, gate counter and out_valid
//   and loads the register defaults. Configuration writes (cfg_we, cfg_index,
//   cfg_data) are taken unchecked; the user must make them only while idle.
module radar_velocity_texture_spin_censor_unit #(
  parameter int MAX_GATES    = rvtsc_pkg::MAX_GATES_DEF,
  parameter int WINDOW_GATES = rvtsc_pkg::WINDOW_GATES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] gate_velocity,
  input  logic               velocity_missing,
  input  logic               end_of_beam,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [11:0]        gate_index,
  output logic               censor,
  output logic [15:0]        texture_interest,
  output logic [15:0]        spin_interest,
  output logic               beam_done
);

  localparam int HALF = WINDOW_GATES / 2;
  localparam int CW   = $clog2(MAX_GATES);
  localparam int SUMW = 32 + $clog2(WINDOW_GATES);
  localparam int SQW  = SUMW + 16 + ((SUMW + 16) % 2);
  localparam int RTW  = SQW / 2;
  localparam int TW   = RTW + 8;
  localparam int NUMW = rvtsc_pkg::CURVE_NUM_W;
  localparam int DW   = (TW > NUMW) ? ((TW > SUMW) ? TW : SUMW) :
                        ((NUMW > SUMW) ? NUMW : SUMW);
  localparam int STW  = $clog2(DW + 1);
  localparam int KW   = $clog2(WINDOW_GATES);
  localparam int FW   = $clog2(HALF) + 1;
  localparam int SCW  = $clog2(WINDOW_GATES + 1);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SQ      = 4'd1;
  localparam logic [3:0] ST_MS_GO   = 4'd2;
  localparam logic [3:0] ST_MS_WAIT = 4'd3;
  localparam logic [3:0] ST_RT_GO   = 4'd4;
  localparam logic [3:0] ST_RT_WAIT = 4'd5;
  localparam logic [3:0] ST_TD_GO   = 4'd6;
  localparam logic [3:0] ST_TD_WAIT = 4'd7;
  localparam logic [3:0] ST_CV_X    = 4'd8;
  localparam logic [3:0] ST_CV_SQ   = 4'd9;
  localparam logic [3:0] ST_CV_GO   = 4'd10;
  localparam logic [3:0] ST_CV_WAIT = 4'd11;
  localparam logic [3:0] ST_PR      = 4'd12;
  localparam logic [3:0] ST_PR_CMP  = 4'd13;
  localparam logic [3:0] ST_EMIT    = 4'd14;
  localparam logic [3:0] ST_FLUSH   = 4'd15;

  // configuration
  logic [14:0] nyquist;
  logic [15:0] tex_upper;
  logic [15:0] threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      nyquist   <= rvtsc_pkg::NYQUIST_RST;
      tex_upper <= rvtsc_pkg::TEX_UPPER_RST;
      threshold <= rvtsc_pkg::THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rvtsc_pkg::REG_NYQUIST:   nyquist   <= cfg_data[14:0];
        rvtsc_pkg::REG_TEX_UPPER: tex_upper <= cfg_data;
        rvtsc_pkg::REG_THRESHOLD: threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [3:0]  state;
  logic [14:0] nyq_eff;
  logic        accept;

  logic signed [15:0] vw [WINDOW_GATES];
  logic               mw [WINDOW_GATES];
  logic signed [16:0] dw [WINDOW_GATES];
  logic signed [16:0] work [WINDOW_GATES];
  logic [CW-1:0]      gate_counter;
  logic [CW-1:0]      g_cur;
  logic               eob_cur;

  logic signed [18:0] diff_raw;
  logic signed [18:0] diff_fold;
  logic signed [18:0] nyq_s;
  logic signed [16:0] d_new;

  assign nyq_eff  = (nyquist == 15'd0) ? 15'd1 : nyquist;
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    nyq_s    = $signed({4'b0, nyq_eff});
    diff_raw = 19'(gate_velocity) - 19'(vw[WINDOW_GATES-1]);
    if (diff_raw > nyq_s) begin
      diff_fold = diff_raw - (nyq_s <<< 1);
    end else if (diff_raw < -nyq_s) begin
      diff_fold = diff_raw + (nyq_s <<< 1);
    end else begin
      diff_fold = diff_raw;
    end
    if (gate_counter == '0) begin
      d_new = '0;
    end else if (velocity_missing || mw[WINDOW_GATES-1]) begin
      d_new = $signed(17'(nyq_eff >> 1));
    end else begin
      d_new = diff_fold[16:0];
    end
  end

  // spin count over adjacent difference pairs
  logic [KW-1:0] k_comb;
  always_comb begin
    logic opp;
    logic big;
    k_comb = '0;
    for (int i = 1; i < WINDOW_GATES; i++) begin
      opp = (dw[i-1] < 0 && dw[i] > 0) || (dw[i-1] > 0 && dw[i] < 0);
      big = ({rvtsc_pkg::mag17(dw[i-1]), 2'b00} > 19'(nyq_eff)) ||
            ({rvtsc_pkg::mag17(dw[i]), 2'b00} > 19'(nyq_eff));
      if (mw[i] || mw[i-1] || (opp && big)) begin
        k_comb = k_comb + KW'(1);
      end
    end
  end

  // shared multiplier
  logic [16:0] mul_a;
  logic [16:0] mul_b;
  logic [33:0] prod;

  // datapath registers
  logic [SCW-1:0]  sq_cnt;
  logic [SUMW-1:0] sum;
  logic [SUMW-1:0] ms;
  logic [RTW-1:0]  rt;
  logic [TW-1:0]   tq;
  logic [KW-1:0]   k_reg;
  logic            phase;
  logic            cv_low;
  logic [15:0]     cv_a;
  logic [31:0]     den;
  logic [15:0]     ti;
  logic [15:0]     si;
  logic            cen;
  logic [FW-1:0]   fi;

  logic [TW-1:0] cv_x;
  logic [15:0]   cv_x1;
  logic [15:0]   cv_x16;
  logic [16:0]   cv_q;
  logic [15:0]   cv_res;

  always_comb begin
    cv_x   = phase ? TW'(k_reg) : tq;
    cv_x1  = phase ? 16'(WINDOW_GATES - 1) : tex_upper;
    cv_x16 = cv_x[15:0];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_SQ: begin
        mul_a = rvtsc_pkg::mag17(work[0]);
        mul_b = rvtsc_pkg::mag17(work[0]);
      end
      ST_CV_X: begin
        mul_a = 17'(cv_x1);
        mul_b = 17'(cv_x1);
      end
      ST_CV_SQ: begin
        mul_a = 17'(cv_a);
        mul_b = 17'(cv_a);
      end
      ST_PR: begin
        mul_a = 17'(ti);
        mul_b = 17'(si);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // serial units
  logic            div_start;
  logic [DW-1:0]   div_dividend;
  logic [31:0]     div_divisor;
  logic [STW-1:0]  div_steps;
  logic            div_done;
  logic [DW-1:0]   div_quot;
  logic            rt_start;
  logic            rt_done;
  logic [RTW-1:0]  rt_root;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    div_steps    = '0;
    unique case (state)
      ST_MS_GO: begin
        div_start    = 1'b1;
        div_dividend = DW'(sum) << (DW - SUMW);
        div_divisor  = 32'(WINDOW_GATES);
        div_steps    = STW'(SUMW);
      end
      ST_TD_GO: begin
        div_start    = 1'b1;
        div_dividend = DW'({rt, 8'b0}) << (DW - TW);
        div_divisor  = 32'(nyq_eff);
        div_steps    = STW'(TW);
      end
      ST_CV_GO: begin
        div_start    = 1'b1;
        div_dividend = DW'({prod[31:0], 17'b0}) << (DW - NUMW);
        div_divisor  = den;
        div_steps    = STW'(NUMW);
      end
      default: ;
    endcase
  end

  assign rt_start = (state == ST_RT_GO);

  rvtsc_div #(
    .DW (DW),
    .VW (rvtsc_pkg::DIVISOR_W),
    .STW(STW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .steps   (div_steps),
    .done    (div_done),
    .quotient(div_quot)
  );

  rvtsc_sqrt #(
    .SQW(SQW),
    .RTW(RTW)
  ) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (rt_start),
    .radicand(SQW'({ms, 16'b0})),
    .done    (rt_done),
    .root    (rt_root)
  );

  always_comb begin
    cv_q = div_quot[16:0];
    if (cv_low) begin
      cv_res = cv_q[15:0];
    end else if (cv_q == 17'd0) begin
      cv_res = rvtsc_pkg::SAT_INTEREST;
    end else begin
      cv_res = 16'(17'h10000 - cv_q);
    end
  end

  logic slot_free;
  logic emit;
  assign slot_free = !out_valid || out_ready;
  assign emit      = slot_free && ((state == ST_EMIT) ||
                                   ((state == ST_FLUSH) && (g_cur >= CW'(fi))));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      gate_counter <= '0;
      out_valid    <= 1'b0;
      phase        <= 1'b0;
      sq_cnt       <= '0;
      fi           <= '0;
      for (int i = 0; i < WINDOW_GATES; i++) begin
        vw[i] <= '0;
        mw[i] <= 1'b0;
        dw[i] <= '0;
      end
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            for (int i = 0; i < WINDOW_GATES - 1; i++) begin
              vw[i]   <= vw[i+1];
              mw[i]   <= mw[i+1];
              dw[i]   <= dw[i+1];
              work[i] <= dw[i+1];
            end
            vw[WINDOW_GATES-1]   <= gate_velocity;
            mw[WINDOW_GATES-1]   <= velocity_missing;
            dw[WINDOW_GATES-1]   <= d_new;
            work[WINDOW_GATES-1] <= d_new;
            g_cur   <= gate_counter;
            eob_cur <= end_of_beam;
            sum     <= '0;
            sq_cnt  <= '0;
            phase   <= 1'b0;
            fi      <= FW'(HALF - 1);
            ti      <= '0;
            si      <= '0;
            cen     <= 1'b0;
            if (end_of_beam) begin
              gate_counter <= '0;
            end else if (gate_counter < CW'(MAX_GATES - 1)) begin
              gate_counter <= gate_counter + CW'(1);
            end
            if (gate_counter >= CW'(WINDOW_GATES - 1)) begin
              state <= ST_SQ;
            end else if (gate_counter >= CW'(HALF)) begin
              state <= ST_EMIT;
            end else if (end_of_beam) begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_SQ: begin
          // square one difference a cycle, add the previous square
          if (sq_cnt == '0) begin
            k_reg <= k_comb;
          end else begin
            sum <= sum + SUMW'(prod);
          end
          for (int i = 0; i < WINDOW_GATES - 1; i++) begin
            work[i] <= work[i+1];
          end
          sq_cnt <= sq_cnt + SCW'(1);
          if (sq_cnt == SCW'(WINDOW_GATES)) begin
            state <= ST_MS_GO;
          end
        end
        ST_MS_GO: state <= ST_MS_WAIT;
        ST_MS_WAIT: begin
          if (div_done) begin
            ms    <= div_quot[SUMW-1:0];
            state <= ST_RT_GO;
          end
        end
        ST_RT_GO: state <= ST_RT_WAIT;
        ST_RT_WAIT: begin
          if (rt_done) begin
            rt    <= rt_root;
            state <= ST_TD_GO;
          end
        end
        ST_TD_GO: state <= ST_TD_WAIT;
        ST_TD_WAIT: begin
          if (div_done) begin
            tq    <= div_quot[TW-1:0];
            state <= ST_CV_X;
          end
        end
        ST_CV_X: begin
          // trivial ends of the curve skip the divide
          if (cv_x == '0 || cv_x >= TW'(cv_x1)) begin
            if (phase) begin
              si    <= (cv_x == '0) ? rvtsc_pkg::LOW_INTEREST : rvtsc_pkg::HIGH_INTEREST;
              state <= ST_PR;
            end else begin
              ti    <= (cv_x == '0) ? rvtsc_pkg::LOW_INTEREST : rvtsc_pkg::HIGH_INTEREST;
              phase <= 1'b1;
            end
          end else begin
            cv_low <= {cv_x16, 1'b0} <= {1'b0, cv_x1};
            cv_a   <= ({cv_x16, 1'b0} <= {1'b0, cv_x1}) ? cv_x16 : (cv_x1 - cv_x16);
            state  <= ST_CV_SQ;
          end
        end
        ST_CV_SQ: begin
          den   <= prod[31:0];
          state <= ST_CV_GO;
        end
        ST_CV_GO: state <= ST_CV_WAIT;
        ST_CV_WAIT: begin
          if (div_done) begin
            if (phase) begin
              si    <= cv_res;
              state <= ST_PR;
            end else begin
              ti    <= cv_res;
              phase <= 1'b1;
              state <= ST_CV_X;
            end
          end
        end
        ST_PR: state <= ST_PR_CMP;
        ST_PR_CMP: begin
          cen   <= prod > {2'b00, threshold, 16'b0};
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            gate_index       <= 12'(g_cur - CW'(HALF));
            censor           <= cen;
            texture_interest <= ti;
            spin_interest    <= si;
            beam_done        <= 1'b0;
            state            <= eob_cur ? ST_FLUSH : ST_IDLE;
          end
        end
        ST_FLUSH: begin
          // release the tail gates, skipping any the beam never had
          if (g_cur < CW'(fi) || slot_free) begin
            if (g_cur >= CW'(fi)) begin
              gate_index       <= 12'(g_cur - CW'(fi));
              censor           <= 1'b0;
              texture_interest <= '0;
              spin_interest    <= '0;
              beam_done        <= (fi == '0);
            end
            if (fi == '0) begin
              state <= ST_IDLE;
            end else begin
              fi <= fi - FW'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/rvtsc_chk.sv -----
// Port-level checks for the velocity texture and spin censor.
// Bound to radar_velocity_texture_spin_censor_unit; no package use.
module rvtsc_chk (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        censor,
  input logic [15:0] texture_interest,
  input logic [15:0] spin_interest,
  input logic        beam_done
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && beam_done |-> !censor && texture_interest == 16'd0 &&
                               spin_interest == 16'd0)
    else $error("beam end result carries interest");

  a_censor_interest: assert property (@(posedge clk) disable iff (rst)
    out_valid && censor |-> texture_interest != 16'd0 && spin_interest != 16'd0)
    else $error("censor without interest");

endmodule

bind radar_velocity_texture_spin_censor_unit rvtsc_chk u_chk (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .censor          (censor),
  .texture_interest(texture_interest),
  .spin_interest   (spin_interest),
  .beam_done       (beam_done)
);

// ----- tb/tb_radar_velocity_texture_spin_censor_unit.sv -----
// Self-checking testbench for radar_velocity_texture_spin_censor_unit.
// Depends on rvtsc_pkg and the unit's RTL; a built-in gate predictor supplies expected results.

module tb_radar_velocity_texture_spin_censor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 3000000;
  localparam int     DRAIN_CYCLES = 400;

  typedef struct {
    logic signed [15:0] vel;
    logic               miss;
    logic               eob;
  } gate_t;

  typedef struct {
    logic [11:0] gidx;
    logic        cen;
    logic [15:0] tex;
    logic [15:0] spin;
    logic        done;
  } verdict_t;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 0, in_ready;
  logic signed [15:0] gate_velocity = '0;
  logic velocity_missing = 0, end_of_beam = 0;
  logic out_valid, out_ready = 0;
  logic [11:0] gate_index;
  logic censor, beam_done;
  logic [15:0] texture_interest, spin_interest;

  radar_velocity_texture_spin_censor_unit u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .gate_velocity(gate_velocity),
    .velocity_missing(velocity_missing), .end_of_beam(end_of_beam),
    .out_valid(out_valid), .out_ready(out_ready), .gate_index(gate_index),
    .censor(censor), .texture_interest(texture_interest),
    .spin_interest(spin_interest), .beam_done(beam_done)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  gate_t    gate_queue[$];
  verdict_t verdict_queue[$];
  int unsigned errors = 0, gates_taken = 0, gates_issued = 0, verdicts_seen = 0;
  int unsigned censored_seen = 0;
  longint cycles = 0;
  int idle_mode = 0;

  // Predictor state
  logic [14:0] p_nyq;
  logic [15:0] p_tex_up, p_thr;
  int          p_vel[5], p_diff[5];
  bit          p_miss[5];
  int unsigned p_gate;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, c;
    r = 0;
    for (int b = 30; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [15:0] interest(longint unsigned x, longint unsigned x1);
    longint unsigned den, val, rem;
    if (x == 0) return rvtsc_pkg::LOW_INTEREST;
    if (x >= x1) return rvtsc_pkg::HIGH_INTEREST;
    den = x1 * x1;
    if (2 * x <= x1) return 16'((x * x * 131072) / den);
    rem = x1 - x;
    val = 65536 - (rem * rem * 131072) / den;
    if (val > 65535) val = 65535;
    return 16'(val);
  endfunction

  function automatic verdict_t make_verdict(int unsigned g, bit c, logic [15:0] t,
                                            logic [15:0] s, bit dn);
    verdict_t r;
    r.gidx = g[11:0]; r.cen = c; r.tex = t; r.spin = s; r.done = dn;
    return r;
  endfunction

  task automatic predict_gate(gate_t it);
    int nyq, d, v, a, b, aa, bb;
    int unsigned g, k;
    longint unsigned sum, r, t;
    logic [15:0] ti, si;
    bit cen;
    v = it.vel;
    nyq = (p_nyq == 0) ? 1 : int'(p_nyq);
    g = p_gate;
    if (g == 0) d = 0;
    else if (it.miss || p_miss[4]) d = nyq >>> 1;
    else begin
      d = v - p_vel[4];
      if (d > nyq) d -= 2 * nyq;
      else if (d < -nyq) d += 2 * nyq;
    end
    for (int i = 0; i < 4; i++) begin
      p_vel[i] = p_vel[i+1]; p_miss[i] = p_miss[i+1]; p_diff[i] = p_diff[i+1];
    end
    p_vel[4] = v; p_miss[4] = it.miss; p_diff[4] = d;
    if (g >= 2) begin
      ti = 0; si = 0; cen = 0;
      if (g >= 4) begin
        sum = 0;
        for (int i = 0; i < 5; i++) sum += longint'(p_diff[i]) * longint'(p_diff[i]);
        r = isqrt((sum / 5) << 16);
        t = (r << 8) / longint'(nyq);
        ti = interest(t, p_tex_up);
        k = 0;
        for (int i = 1; i < 5; i++) begin
          a = p_diff[i-1]; b = p_diff[i];
          aa = a < 0 ? -a : a; bb = b < 0 ? -b : b;
          if (p_miss[i] || p_miss[i-1]) k++;
          else if (((a < 0 && b > 0) || (a > 0 && b < 0)) &&
                   (4 * aa > nyq || 4 * bb > nyq)) k++;
        end
        si = interest(k, 4);
        cen = (longint'(ti) * longint'(si)) > (longint'(p_thr) << 16);
      end
      verdict_queue.push_back(make_verdict(g - 2, cen, ti, si, 0));
    end
    if (it.eob) begin
      for (int i = 1; i >= 0; i--)
        if (g >= i) verdict_queue.push_back(make_verdict(g - i, 0, 0, 0, i == 0));
      p_gate = 0;
    end else if (g < 4095) begin
      p_gate = g + 1;
    end
  endtask

  // Input transaction capture and output check
  always @(posedge clk) begin
    verdict_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_radar_velocity_texture_spin_censor_unit: done, errors");
      $finish;
    end else if (!rst) begin
      if (in_valid && in_ready) begin
        predict_gate('{gate_velocity, velocity_missing, end_of_beam});
        gates_taken++;
      end
      if (out_valid && out_ready) begin
        verdicts_seen++;
        if (verdict_queue.size() == 0) begin
          $error("unexpected result, gate_index %0d", gate_index);
          errors++;
        end else begin
          e = verdict_queue.pop_front();
          if (censor) censored_seen++;
          if (gate_index !== e.gidx) begin
            $error("gate_index: expected %0d, got %0d", e.gidx, gate_index); errors++;
          end
          if (censor !== e.cen) begin
            $error("censor: expected %0d, got %0d", e.cen, censor); errors++;
          end
          if (texture_interest !== e.tex) begin
            $error("texture_interest: expected %0d, got %0d", e.tex, texture_interest);
            errors++;
          end
          if (spin_interest !== e.spin) begin
            $error("spin_interest: expected %0d, got %0d", e.spin, spin_interest); errors++;
          end
          if (beam_done !== e.done) begin
            $error("beam_done: expected %0d, got %0d", e.done, beam_done); errors++;
          end
        end
      end
    end
  end

  // Driver: random out_ready; advance to the next gate once the current transaction is taken
  always @(negedge clk) begin
    gate_t it;
    int send_idle, recv_idle;
    send_idle = (idle_mode == 0) ? 35 : (idle_mode == 1) ? 79 : 0;
    recv_idle = (idle_mode == 0) ? 79 : (idle_mode == 1) ? 35 : 0;
    if (!rst) begin
      out_ready <= ($urandom_range(99) >= recv_idle);
      if (!in_valid || gates_taken == gates_issued) begin
        if (gate_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
          it = gate_queue.pop_front();
          gate_velocity <= it.vel;
          velocity_missing <= it.miss;
          end_of_beam <= it.eob;
          in_valid <= 1;
          gates_issued++;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      rvtsc_pkg::REG_NYQUIST:   p_nyq = val[14:0];
      rvtsc_pkg::REG_TEX_UPPER: p_tex_up = val;
      rvtsc_pkg::REG_THRESHOLD: p_thr = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (gate_queue.size() != 0 || gates_taken != gates_issued ||
           verdict_queue.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_gate(int v, bit m, bit e);
    gate_t it;
    it.vel = 16'(v); it.miss = m; it.eob = e;
    gate_queue.push_back(it);
  endtask

  task automatic random_beams(int n_items);
    int len, sel, v, spread;
    while (n_items > 0) begin
      sel = $urandom_range(99);
      len = (sel < 80) ? $urandom_range(5, 24) : (sel < 95) ? $urandom_range(1, 4)
                                                             : $urandom_range(25, 60);
      spread = 1 << $urandom_range(15);
      v = $urandom_range(65535) - 32768;
      for (int i = 0; i < len; i++) begin
        sel = $urandom_range(99);
        if (sel < 60) v = v + $urandom_range(2 * spread) - spread;
        else if (sel < 90) v = $urandom_range(65535) - 32768;
        else v = (sel & 1) ? 32767 : -32768;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        add_gate(v, $urandom_range(9) == 0, i == len - 1);
      end
      n_items -= len;
    end
  endtask

  initial begin
    p_nyq = rvtsc_pkg::NYQUIST_RST;
    p_tex_up = rvtsc_pkg::TEX_UPPER_RST;
    p_thr = rvtsc_pkg::THRESHOLD_RST;
    for (int i = 0; i < 5; i++) begin
      p_vel[i] = 0; p_diff[i] = 0; p_miss[i] = 0;
    end
    p_gate = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: extremes, folding, missing gates, short beams
    add_gate(32767, 0, 0); add_gate(-32768, 0, 0); add_gate(32767, 0, 0);
    add_gate(0, 1, 0); add_gate(-32768, 0, 0); add_gate(100, 0, 0);
    add_gate(-100, 0, 0); add_gate(6400, 0, 0); add_gate(-6400, 1, 1);
    add_gate(5, 0, 1);
    add_gate(7, 1, 0); add_gate(9, 0, 1);
    add_gate(1, 0, 0); add_gate(2, 0, 0); add_gate(3, 0, 1);
    add_gate(10, 0, 0); add_gate(10, 0, 0); add_gate(10, 0, 0); add_gate(10, 0, 1);
    add_gate(0, 0, 0); add_gate(0, 0, 0); add_gate(0, 0, 0); add_gate(0, 0, 0);
    add_gate(0, 0, 1);
    random_beams(90);
    drain();

    idle_mode = 0;
    write_reg(rvtsc_pkg::REG_NYQUIST, 16'hFFFF);
    write_reg(rvtsc_pkg::REG_TEX_UPPER, 16'd1);
    write_reg(rvtsc_pkg::REG_THRESHOLD, 16'hFFFF);
    write_reg(2'd3, 16'h1234);
    random_beams(90);
    drain();

    idle_mode = 1;
    write_reg(rvtsc_pkg::REG_NYQUIST, 16'd1);
    write_reg(rvtsc_pkg::REG_TEX_UPPER, 16'hFFFF);
    write_reg(rvtsc_pkg::REG_THRESHOLD, 16'd0);
    random_beams(90);
    drain();

    write_reg(rvtsc_pkg::REG_NYQUIST, 16'd0);
    write_reg(rvtsc_pkg::REG_TEX_UPPER, 16'd0);
    random_beams(90);
    drain();

    idle_mode = 2;
    write_reg(rvtsc_pkg::REG_NYQUIST, 16'($urandom_range(1, 32767)));
    write_reg(rvtsc_pkg::REG_TEX_UPPER, 16'($urandom_range(1, 65535)));
    write_reg(rvtsc_pkg::REG_THRESHOLD, 16'($urandom_range(65535)));
    random_beams(90);
    drain();

    $display("covered %0d gates and %0d results (%0d censored) over five register settings",
             gates_taken, verdicts_seen, censored_seen);
    if (errors == 0) begin
      $display("tb_radar_velocity_texture_spin_censor_unit: done, clean");
    end else begin
      $display("tb_radar_velocity_texture_spin_censor_unit: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/rvtsc_pkg.sv
hdl/rvtsc_div.sv
hdl/rvtsc_sqrt.sv
hdl/radar_velocity_texture_spin_censor_unit.sv
hdl/rvtsc_chk.sv
tb/tb_radar_velocity_texture_spin_censor_unit.sv
